[hdl/isa_pkg.sv]
`default_nettype none
package isa_pkg;

  // operation codes carried in the kind field
  localparam logic [3:0] KIND_INSERT_AT    = 4'd0;
  localparam logic [3:0] KIND_APPEND       = 4'd1;
  localparam logic [3:0] KIND_READ         = 4'd2;
  localparam logic [3:0] KIND_OVERWRITE    = 4'd3;
  localparam logic [3:0] KIND_REMOVE_LAST  = 4'd4;
  localparam logic [3:0] KIND_REMOVE_AT    = 4'd5;
  localparam logic [3:0] KIND_REMOVE_VALUE = 4'd6;
  localparam logic [3:0] KIND_CONTAINS     = 4'd7;
  localparam logic [3:0] KIND_CLEAR        = 4'd8;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  // what every cell does with its stored word on a commit
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_WRITE,
    OP_INSERT,
    OP_DELETE,
    OP_DELETE_FOUND
  } cell_op_t;

  // control broadcast from the sequencer to all cells
  typedef struct packed {
    cell_op_t           op;
    logic               scan;
    logic signed [31:0] word;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

endpackage
`default_nettype wire

[hdl/isa_cell.sv]
`default_nettype none
module isa_cell #(
  parameter int INDEX = 0,
  parameter int AW    = 7
) (
  input  wire logic               clk,
  input  wire isa_pkg::cell_cmd_t cmd,
  input  wire logic [AW-1:0]      at,
  input  wire logic [AW-1:0]      count,
  input  wire logic signed [31:0] left_data,
  input  wire logic signed [31:0] right_data,
  input  wire logic               left_found,
  input  wire logic signed [31:0] left_pass,
  output logic signed [31:0]      data,
  output logic                    found,
  output logic signed [31:0]      pass
);

  localparam logic [AW-1:0] ME = AW'(INDEX);

  logic signed [31:0] data_r, data_nxt;
  logic               found_r, found_nxt;
  logic signed [31:0] pass_r, pass_nxt;
  logic               here, above, valid;

  assign here  = (at == ME);
  assign above = (ME > at);
  assign valid = (ME < count);

  // stored word: write, shift up from the left or down from the right
  always_comb begin
    case (cmd.op)
      isa_pkg::OP_WRITE:        data_nxt = here ? cmd.word : data_r;
      isa_pkg::OP_INSERT:       data_nxt = here ? cmd.word : (above ? left_data : data_r);
      isa_pkg::OP_DELETE:       data_nxt = (here || above) ? right_data : data_r;
      isa_pkg::OP_DELETE_FOUND: data_nxt = found_r ? right_data : data_r;
      default:                  data_nxt = data_r;
    endcase
  end

  // scan chain: running "match seen at or below me", and the read tap
  assign found_nxt = left_found | (valid && (data_r == cmd.word));
  assign pass_nxt  = here ? data_r : left_pass;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (cmd.scan) begin
      found_r <= found_nxt;
      pass_r  <= pass_nxt;
    end
  end

  assign data  = data_r;
  assign found = found_r;
  assign pass  = pass_r;

endmodule
`default_nettype wire

[hdl/indexed_shift_array_core.sv]
`default_nettype none
// Packed ordered store of up to DEPTH signed 32-bit words held in a row of
// cells, one word per cell. Insert, append, overwrite, remove, remove-last
// and clear are captured in S_IDLE, then committed in S_EXEC once the
// output register is free; every cell writes or shifts from its neighbor
// at once. Read, remove_value and contains pass S_SCAN first: a match
// flag and a read tap ripple down the cell chain one cell per cycle, so
// their time is set by the chain length. One request is in work at a time;
// a finished result sits in the output register and the next request is
// taken while it waits. Only the entry_count low 7 bits leave the block.
module indexed_shift_array_core #(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // position[6:0], word[38:7], zero[39]
  input  wire logic [3:0]  in_tuser,   // kind[3:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // status[2:0], read_data[34:3], present[35],
                                       // entry_count[42:36], zero[47:43]
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int AW = (CW > 7) ? CW : 7;
  localparam logic [AW-1:0] FULL_M = AW'(DEPTH);

  isa_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [IW-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic [3:0]         kind_r;
  logic [6:0]         pos_r;
  logic signed [31:0] word_r;
  logic               out_valid_r;
  logic [47:0]        out_data_r, out_data_nxt;

  logic               accept, slot_free, commit;
  logic [AW-1:0]      pos_m, cnt_m, at_m;
  isa_pkg::cell_cmd_t cmd;
  isa_pkg::cell_op_t  op_sel;
  isa_pkg::status_t   status;
  logic signed [31:0] rdata;
  logic               present;
  logic               use_count_at;

  logic signed [31:0] data_w  [DEPTH];
  logic               found_w [DEPTH];
  logic signed [31:0] pass_w  [DEPTH];

  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign commit    = (state_r == isa_pkg::S_EXEC) && slot_free;
  assign pos_m     = AW'(pos_r);
  assign cnt_m     = AW'(count_r);
  assign at_m      = use_count_at ? cnt_m : pos_m;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    in_tready    = 1'b0;
    case (state_r)
      isa_pkg::S_IDLE: begin
        in_tready    = 1'b1;
        scan_cnt_nxt = '0;
        if (in_tvalid) begin
          if (in_tuser == isa_pkg::KIND_READ || in_tuser == isa_pkg::KIND_REMOVE_VALUE ||
              in_tuser == isa_pkg::KIND_CONTAINS) begin
            state_nxt = isa_pkg::S_SCAN;
          end else begin
            state_nxt = isa_pkg::S_EXEC;
          end
        end
      end
      isa_pkg::S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == IW'(DEPTH - 1)) begin
          state_nxt = isa_pkg::S_EXEC;
        end
      end
      isa_pkg::S_EXEC: begin
        if (slot_free) begin
          state_nxt = isa_pkg::S_IDLE;
        end
      end
      default: state_nxt = isa_pkg::S_IDLE;
    endcase
  end

  // operation decode: status, count update and cell action
  always_comb begin
    status       = isa_pkg::ST_OK;
    rdata        = '0;
    present      = 1'b0;
    count_nxt    = count_r;
    op_sel       = isa_pkg::OP_HOLD;
    use_count_at = 1'b0;
    case (kind_r)
      isa_pkg::KIND_INSERT_AT: begin
        if (pos_m > cnt_m) begin
          status = isa_pkg::ST_RANGE;
        end else if (cnt_m >= FULL_M) begin
          status = isa_pkg::ST_FULL;
        end else begin
          op_sel    = isa_pkg::OP_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      isa_pkg::KIND_APPEND: begin
        use_count_at = 1'b1;
        if (cnt_m >= FULL_M) begin
          status = isa_pkg::ST_FULL;
        end else begin
          op_sel    = isa_pkg::OP_WRITE;
          count_nxt = count_r + 1'b1;
        end
      end
      isa_pkg::KIND_READ: begin
        if (pos_m >= cnt_m) begin
          status = isa_pkg::ST_RANGE;
        end else begin
          rdata = pass_w[DEPTH-1];
        end
      end
      isa_pkg::KIND_OVERWRITE: begin
        if (pos_m >= cnt_m) begin
          status = isa_pkg::ST_RANGE;
        end else begin
          op_sel = isa_pkg::OP_WRITE;
        end
      end
      isa_pkg::KIND_REMOVE_LAST: begin
        if (count_r == '0) begin
          status = isa_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      isa_pkg::KIND_REMOVE_AT: begin
        if (count_r == '0) begin
          status = isa_pkg::ST_EMPTY;
        end else if (pos_m >= cnt_m) begin
          status = isa_pkg::ST_RANGE;
        end else begin
          op_sel    = isa_pkg::OP_DELETE;
          count_nxt = count_r - 1'b1;
        end
      end
      isa_pkg::KIND_REMOVE_VALUE: begin
        if (count_r == '0) begin
          status = isa_pkg::ST_EMPTY;
        end else if (!found_w[DEPTH-1]) begin
          status = isa_pkg::ST_MISSING;
        end else begin
          op_sel    = isa_pkg::OP_DELETE_FOUND;
          count_nxt = count_r - 1'b1;
        end
      end
      isa_pkg::KIND_CONTAINS: begin
        present = found_w[DEPTH-1];
      end
      isa_pkg::KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign cmd.op   = commit ? op_sel : isa_pkg::OP_HOLD;
  assign cmd.scan = (state_r == isa_pkg::S_SCAN);
  assign cmd.word = word_r;

  assign out_data_nxt = {5'd0, 7'(count_nxt), present, rdata, status};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isa_pkg::S_IDLE;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_tuser;
      pos_r  <= in_tdata[6:0];
      word_r <= in_tdata[38:7];
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  // cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left_d, right_d, left_p;
    logic               left_f;
    if (g == 0) begin : g_first
      assign left_d = '0;
      assign left_f = 1'b0;
      assign left_p = '0;
    end else begin : g_mid
      assign left_d = data_w[g-1];
      assign left_f = found_w[g-1];
      assign left_p = pass_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = data_w[g];
    end else begin : g_inner
      assign right_d = data_w[g+1];
    end
    isa_cell #(
      .INDEX (g),
      .AW    (AW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .at         (at_m),
      .count      (cnt_m),
      .left_data  (left_d),
      .right_data (right_d),
      .left_found (left_f),
      .left_pass  (left_p),
      .data       (data_w[g]),
      .found      (found_w[g]),
      .pass       (pass_w[g])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    AW'(count_r) <= FULL_M)
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == isa_pkg::ST_FULL) |-> (AW'(count_r) == FULL_M))
    else $error("full status while store not full");

  a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (state_r == isa_pkg::S_IDLE) && out_tvalid)
    else $error("commit did not post a result");

endmodule
`default_nettype wire

[verif/isa_result_checker.sv]
`default_nettype none
module isa_result_checker #(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,   // position[6:0], word[38:7], zero[39]
  input  wire logic [3:0]  in_tuser,   // kind[3:0]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [47:0] out_tdata,  // status[2:0], read_data[34:3], present[35],
                                       // entry_count[42:36], zero[47:43]
  output int               err_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    isa_pkg::status_t   status;
    logic signed [31:0] read_data;
    logic               present;
    logic [6:0]         entry_count;
  } op_result_t;

  // shadow copy of the store
  logic signed [31:0] model_words [DEPTH];
  int                 model_fill;

  op_result_t awaited_results[$];
  op_result_t oldest;

  initial begin
    err_count = 0;
    pending   = 0;
  end

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    // keep the log short when the block is badly broken
    if (err_count < 40)
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    err_count++;
  endtask

  // index of the first valid entry equal to w, or -1
  function automatic int find_word(logic signed [31:0] w);
    int hit;
    hit = -1;
    for (int i = 0; i < model_fill; i++)
      if (hit < 0 && model_words[i] == w) hit = i;
    return hit;
  endfunction

  // apply one request to the shadow store and return the result it gives
  function automatic op_result_t predict_result(logic [3:0] kind, logic [6:0] pos,
                                                logic signed [31:0] w);
    op_result_t r;
    int         at;
    int         p;
    r.status    = isa_pkg::ST_OK;
    r.read_data = '0;
    r.present   = 1'b0;
    p = int'(pos);
    case (kind)
      isa_pkg::KIND_INSERT_AT: begin
        // range check wins over full
        if (p > model_fill) r.status = isa_pkg::ST_RANGE;
        else if (model_fill >= DEPTH) r.status = isa_pkg::ST_FULL;
        else begin
          for (int i = model_fill; i > p; i--) model_words[i] = model_words[i-1];
          model_words[p] = w;
          model_fill++;
        end
      end
      isa_pkg::KIND_APPEND: begin
        if (model_fill >= DEPTH) r.status = isa_pkg::ST_FULL;
        else begin
          model_words[model_fill] = w;
          model_fill++;
        end
      end
      isa_pkg::KIND_READ: begin
        if (p >= model_fill) r.status = isa_pkg::ST_RANGE;
        else r.read_data = model_words[p];
      end
      isa_pkg::KIND_OVERWRITE: begin
        if (p >= model_fill) r.status = isa_pkg::ST_RANGE;
        else model_words[p] = w;
      end
      isa_pkg::KIND_REMOVE_LAST: begin
        if (model_fill == 0) r.status = isa_pkg::ST_EMPTY;
        else model_fill--;
      end
      isa_pkg::KIND_REMOVE_AT: begin
        if (model_fill == 0) r.status = isa_pkg::ST_EMPTY;
        else if (p >= model_fill) r.status = isa_pkg::ST_RANGE;
        else begin
          for (int i = p; i + 1 < model_fill; i++) model_words[i] = model_words[i+1];
          model_fill--;
        end
      end
      isa_pkg::KIND_REMOVE_VALUE: begin
        at = find_word(w);
        if (model_fill == 0) r.status = isa_pkg::ST_EMPTY;
        else if (at < 0) r.status = isa_pkg::ST_MISSING;
        else begin
          for (int i = at; i + 1 < model_fill; i++) model_words[i] = model_words[i+1];
          model_fill--;
        end
      end
      isa_pkg::KIND_CONTAINS: r.present = (find_word(w) >= 0);
      isa_pkg::KIND_CLEAR:    model_fill = 0;
      default: ;  // unused kinds do nothing
    endcase
    r.entry_count = model_fill[6:0];
    return r;
  endfunction

  // results are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_results.delete();
      model_fill = 0;
      for (int i = 0; i < DEPTH; i++) model_words[i] = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unrequested result", '0, out_tdata);
        end else begin
          oldest = awaited_results.pop_front();
          if (oldest.status != out_tdata[2:0])
            report_mismatch("status", oldest.status, out_tdata[2:0]);
          if (oldest.read_data != out_tdata[34:3])
            report_mismatch("read_data", oldest.read_data, out_tdata[34:3]);
          if (oldest.present != out_tdata[35])
            report_mismatch("present", oldest.present, out_tdata[35]);
          if (oldest.entry_count != out_tdata[42:36])
            report_mismatch("entry_count", oldest.entry_count, out_tdata[42:36]);
        end
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(predict_result(in_tuser, in_tdata[6:0], in_tdata[38:7]));
    end
    pending <= awaited_results.size();
  end

endmodule
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int RANDOM_REQUESTS = 725;
  localparam logic [3:0] KIND_SPARE_TOP = 4'd15;

  // traffic mixes: cumulative percent per kind, last slot is the unused kinds
  localparam int MIX_GROW   = 0;
  localparam int MIX_EVEN   = 1;
  localparam int MIX_SHRINK = 2;
  localparam int MIX_CUT [3][10] = '{
    '{30, 60, 70, 78, 81, 85, 89, 96, 96, 100},
    '{15, 30, 45, 55, 62, 70, 80, 92, 94, 100},
    '{ 5, 10, 20, 26, 44, 64, 84, 94, 96, 100}
  };
  localparam logic [3:0] KIND_ORDER [9] = '{
    isa_pkg::KIND_INSERT_AT, isa_pkg::KIND_APPEND, isa_pkg::KIND_READ,
    isa_pkg::KIND_OVERWRITE, isa_pkg::KIND_REMOVE_LAST, isa_pkg::KIND_REMOVE_AT,
    isa_pkg::KIND_REMOVE_VALUE, isa_pkg::KIND_CONTAINS, isa_pkg::KIND_CLEAR
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;     // position[6:0], word[38:7], zero[39]
  logic [3:0]  in_tuser = '0;     // kind[3:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // status[2:0], read_data[34:3], present[35],
                                  // entry_count[42:36], zero[47:43]
  int          err_count;
  int          pending;

  // rough fill level and recently stored words, used only to aim requests
  int          approx_fill;
  logic [31:0] recent_words [8];

  indexed_shift_array_core #(.DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  isa_result_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .err_count  (err_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // offer one request and hold it until the block takes it
  task automatic push_request(logic [3:0] kind, logic [6:0] pos, logic [31:0] w);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, w, pos};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [3:0] pick_kind(int mix);
    int r;
    r = $urandom_range(0, 99);
    for (int k = 0; k < 9; k++)
      if (r < MIX_CUT[mix][k]) return KIND_ORDER[k];
    return 4'($urandom_range(int'(isa_pkg::KIND_CLEAR) + 1, int'(KIND_SPARE_TOP)));
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return recent_words[$urandom_range(0, 7)];
    if (r < 48) return 32'h8000_0000;
    if (r < 51) return 32'h7fff_ffff;
    if (r < 53) return 32'hffff_ffff;
    if (r < 55) return 32'h0000_0000;
    return $urandom();
  endfunction

  // mostly inside the valid range, sometimes anywhere in the field
  function automatic logic [6:0] pick_pos(logic [3:0] kind);
    if ($urandom_range(0, 99) < 15) return 7'($urandom_range(0, 127));
    if (kind == isa_pkg::KIND_INSERT_AT) return 7'($urandom_range(0, approx_fill));
    if (approx_fill == 0) return '0;
    return 7'($urandom_range(0, approx_fill - 1));
  endfunction

  // track the fill level loosely so positions stay mostly meaningful
  task automatic track_fill(logic [3:0] kind, logic [6:0] pos, logic [31:0] w);
    case (kind)
      isa_pkg::KIND_INSERT_AT:
        if (int'(pos) <= approx_fill && approx_fill < DEPTH) approx_fill++;
      isa_pkg::KIND_APPEND:       if (approx_fill < DEPTH) approx_fill++;
      isa_pkg::KIND_REMOVE_LAST:  if (approx_fill > 0) approx_fill--;
      isa_pkg::KIND_REMOVE_AT:    if (int'(pos) < approx_fill) approx_fill--;
      isa_pkg::KIND_REMOVE_VALUE:
        if (approx_fill > 0 && $urandom_range(0, 1)) approx_fill--;
      isa_pkg::KIND_CLEAR:        approx_fill = 0;
      default: ;
    endcase
    if (kind == isa_pkg::KIND_INSERT_AT || kind == isa_pkg::KIND_APPEND ||
        kind == isa_pkg::KIND_OVERWRITE)
      recent_words[$urandom_range(0, 7)] = w;
  endtask

  // stimulus
  initial begin
    logic [3:0]  kind;
    logic [6:0]  pos;
    logic [31:0] w;
    int          burst_left;
    int          mix;
    int          mix_left;
    approx_fill = 0;
    for (int i = 0; i < 8; i++) recent_words[i] = $urandom();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, extremes, every operation
    push_request(isa_pkg::KIND_READ, 7'd0, 32'h0);
    push_request(isa_pkg::KIND_OVERWRITE, 7'd0, 32'h1111_1111);
    push_request(isa_pkg::KIND_REMOVE_LAST, 7'd0, 32'h0);
    push_request(isa_pkg::KIND_REMOVE_AT, 7'd0, 32'h0);
    push_request(isa_pkg::KIND_REMOVE_VALUE, 7'd0, 32'h0);
    push_request(isa_pkg::KIND_CONTAINS, 7'd0, 32'h0);
    push_request(isa_pkg::KIND_INSERT_AT, 7'd1, 32'h2222_2222);
    push_request(isa_pkg::KIND_INSERT_AT, 7'd0, 32'h8000_0000);
    push_request(isa_pkg::KIND_APPEND, 7'd0, 32'h7fff_ffff);
    push_request(isa_pkg::KIND_APPEND, 7'd0, 32'hffff_ffff);
    push_request(isa_pkg::KIND_INSERT_AT, 7'd1, 32'h0000_0000);
    push_request(isa_pkg::KIND_READ, 7'd0, 32'h0);
    push_request(isa_pkg::KIND_READ, 7'd4, 32'h0);
    push_request(isa_pkg::KIND_READ, 7'd127, 32'hffff_ffff);
    push_request(isa_pkg::KIND_OVERWRITE, 7'd2, 32'h5555_5555);
    push_request(isa_pkg::KIND_CONTAINS, 7'd0, 32'h8000_0000);
    push_request(isa_pkg::KIND_CONTAINS, 7'd0, 32'h1234_5678);
    push_request(isa_pkg::KIND_REMOVE_VALUE, 7'd0, 32'h1234_5678);
    push_request(isa_pkg::KIND_REMOVE_VALUE, 7'd0, 32'hffff_ffff);
    push_request(isa_pkg::KIND_REMOVE_AT, 7'd5, 32'h0);
    push_request(isa_pkg::KIND_REMOVE_AT, 7'd0, 32'h0);
    push_request(isa_pkg::KIND_REMOVE_LAST, 7'd127, 32'h0);
    push_request(KIND_SPARE_TOP, 7'd127, 32'hffff_ffff);
    push_request(isa_pkg::KIND_CLEAR, 7'd0, 32'h0);
    push_request(isa_pkg::KIND_READ, 7'd0, 32'h0);

    // random: bursts with gaps, mix drifting between filling and draining
    burst_left = $urandom_range(1, 24);
    mix = MIX_GROW;
    mix_left = $urandom_range(60, 140);
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (mix_left == 0) begin
        mix = (mix + 1) % 3;
        mix_left = $urandom_range(60, 140);
      end
      mix_left--;
      kind = pick_kind(mix);
      pos  = pick_pos(kind);
      w    = pick_word();
      push_request(kind, pos, w);
      track_fill(kind, pos, w);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
    in_tvalid <= 1'b0;

    // drain, then watch for stray results
    @(posedge clk);
    wait (pending == 0);
    repeat (DEPTH + 20) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: segments of steady, patchy and sparse ready, two long holds
  initial begin
    int seg;
    int seg_len;
    int style;
    seg = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (seg == 15 || seg == 150) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        seg_len = $urandom_range(5, 60);
        style   = $urandom_range(0, 2);
        repeat (seg_len) begin
          case (style)
            0:       out_tready <= 1'b1;
            1:       out_tready <= ($urandom_range(0, 1) == 1);
            default: out_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
hdl/isa_pkg.sv
hdl/isa_cell.sv
hdl/indexed_shift_array_core.sv
verif/isa_result_checker.sv
verif/tb.sv
